FILE: hw/rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the portfolio candidate scorer.
// ----------------------------------------------------------------------------
package pcs_pkg;

   localparam int WEIGHT_FIELDS   = 5;
   localparam int MAX_ASSETS_DEF  = 5;
   localparam int N_TRACK         = 3;
   localparam int W_IDX_W         = 3;
   localparam int DIV_NW          = 50;
   localparam int DIV_DW          = 32;

   localparam logic [2:0]         COUNT_RESET = 3'd5;
   localparam logic signed [31:0] RATE_RESET  = 32'sd167772;
   localparam logic [31:0]        RISK_SENT   = 32'hFFFF_FFFF;
   localparam logic [31:0]        METRIC_SENT = 32'h8000_0000;

   localparam logic CSR_ASSET_COUNT = 1'b0;
   localparam logic CSR_RISK_FREE   = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_EVAL  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_SUM  = 2'd1,
      ST_ZERO_RISK = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_EXEC,
      S_NORM_GO,
      S_NORM_WAIT,
      S_RET_RD,
      S_RET_MUL,
      S_RET_ACC,
      S_RET_FIN,
      S_VAR_RD,
      S_VAR_MUL,
      S_VAR_ACC,
      S_VAR_ROW,
      S_VAR_ADD,
      S_VAR_FIN,
      S_SQRT_WAIT,
      S_SHP_GO,
      S_SHP_WAIT,
      S_TRACK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] dividend;
      logic [DIV_DW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: hw/rtl/pcs_mem.sv
// ----------------------------------------------------------------------------
// pcs_mem
// Mean and covariance table: one write port, one registered read port.
// Entries never written read as zero.
// ----------------------------------------------------------------------------
module pcs_mem #(
   parameter int DEPTH = 30,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0]      mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [31:0]      rd_raw_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_raw_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : 32'd0;

endmodule

FILE: hw/rtl/pcs_div.sv
// ----------------------------------------------------------------------------
// pcs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pcs_pkg::div_req_type req,
   output pcs_pkg::div_rsp_type rsp
);

   localparam int CW = $clog2(pcs_pkg::DIV_NW);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [pcs_pkg::DIV_NW-1:0] num_ff, num_in;
   logic [pcs_pkg::DIV_DW-1:0] rem_ff, rem_in;
   logic [pcs_pkg::DIV_DW-1:0] den_ff, den_in;
   logic [pcs_pkg::DIV_DW:0]   rem_sh;
   logic [pcs_pkg::DIV_DW+1:0] diff;
   logic                       ge;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[pcs_pkg::DIV_NW-1]};
      diff    = {1'b0, rem_sh} - {2'b00, den_ff};
      ge      = ~diff[pcs_pkg::DIV_DW+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(pcs_pkg::DIV_NW - 1);
         num_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[pcs_pkg::DIV_NW-2:0], ge};
         rem_in = ge ? diff[pcs_pkg::DIV_DW-1:0] : rem_sh[pcs_pkg::DIV_DW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff;

endmodule

FILE: hw/rtl/pcs_sqrt.sv
// ----------------------------------------------------------------------------
// pcs_sqrt
// Integer square root of a 64-bit word, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pcs_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] one_ff, one_in;
   logic [63:0] trial;

   always_comb begin
      trial   = r_ff + one_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      one_in  = one_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         x_in    = radicand;
         r_in    = '0;
         one_in  = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + one_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         one_in = one_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      r_ff   <= r_in;
      one_ff <= one_in;
   end

   assign done = done_ff;
   assign root = r_ff[31:0];

endmodule

FILE: hw/rtl/portfolio_candidate_scorer_unit.sv
// ----------------------------------------------------------------------------
// portfolio_candidate_scorer_unit
// Scores weight vectors against loaded mean and covariance tables and keeps
// the best portfolio for minimum risk, maximum return and maximum Sharpe.
// ----------------------------------------------------------------------------
// One word is worked on at a time; req_stall is low only while the unit is
// idle, and a finished result waits in the rsp register while the next word
// is taken. An evaluate word normalizes each weight through the shared
// bit-serial divider, multiply-accumulates through the registered table
// memory for the return and the variance, takes the square root and divides
// once more for the Sharpe value.
// ----------------------------------------------------------------------------
module portfolio_candidate_scorer_unit #(
   parameter int MAX_ASSETS = pcs_pkg::MAX_ASSETS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [4:0]  req_entry_index,
   input  logic [31:0] req_entry_value,
   input  logic [15:0] req_raw_weight_0,
   input  logic [15:0] req_raw_weight_1,
   input  logic [15:0] req_raw_weight_2,
   input  logic [15:0] req_raw_weight_3,
   input  logic [15:0] req_raw_weight_4,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_port_return,
   output logic [31:0] rsp_port_risk,
   output logic [31:0] rsp_sharpe_value,
   output logic [2:0]  rsp_improved_mask,
   output logic [16:0] rsp_weight_out_0,
   output logic [16:0] rsp_weight_out_1,
   output logic [16:0] rsp_weight_out_2,
   output logic [16:0] rsp_weight_out_3,
   output logic [16:0] rsp_weight_out_4,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int DEPTH = MAX_ASSETS + MAX_ASSETS * MAX_ASSETS;
   localparam int AW    = $clog2(DEPTH);
   localparam int LIM   = (MAX_ASSETS < pcs_pkg::WEIGHT_FIELDS) ?
                          MAX_ASSETS : pcs_pkg::WEIGHT_FIELDS;
   localparam int NW    = pcs_pkg::WEIGHT_FIELDS;
   localparam int NT    = pcs_pkg::N_TRACK;
   localparam int IW    = pcs_pkg::W_IDX_W;

   // configuration
   logic [2:0]         asset_count_ff;
   logic signed [31:0] rate_ff;

   // control
   pcs_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;

   // captured word
   pcs_pkg::kind_type  kind_ff, kind_in;
   logic [4:0]         idx_ff, idx_in;
   logic [31:0]        value_ff, value_in;
   logic [15:0]        raw_ff [NW];
   logic [15:0]        raw_in [NW];
   logic [IW-1:0]      n_ff, n_in;
   logic [IW-1:0]      n_eff;

   // evaluation datapath
   logic [18:0]        sum_ff, sum_in;
   logic [18:0]        sum_c;
   logic [IW-1:0]      i_ff, i_in;
   logic [IW-1:0]      j_ff, j_in;
   logic [AW-1:0]      rowbase_ff, rowbase_in;
   logic [16:0]        w_ff [NW];
   logic [16:0]        w_in [NW];
   logic signed [49:0] prod_ff, prod_in;
   logic signed [52:0] acc_ff, acc_in;
   logic signed [54:0] prod2_ff, prod2_in;
   logic signed [57:0] var_acc_ff, var_acc_in;
   logic               neg_ff, neg_in;
   logic signed [52:0] acc_rnd;
   logic signed [36:0] acc_top;
   logic signed [57:0] var_rnd;
   logic signed [41:0] var_top;
   logic signed [32:0] diff;
   logic [32:0]        mag;

   // result
   pcs_pkg::status_type status_ff, status_in;
   logic signed [31:0] ret_ff, ret_in;
   logic [31:0]        risk_ff, risk_in;
   logic signed [31:0] shp_ff, shp_in;
   logic [2:0]         mask_ff, mask_in;

   // trackers
   logic [NT-1:0]      trk_valid_ff, trk_valid_in;
   logic [31:0]        trk_risk_ff [NT];
   logic [31:0]        trk_risk_in [NT];
   logic signed [31:0] trk_ret_ff [NT];
   logic signed [31:0] trk_ret_in [NT];
   logic signed [31:0] trk_shp_ff [NT];
   logic signed [31:0] trk_shp_in [NT];
   logic [16:0]        trk_w_ff [NT][NW];
   logic [16:0]        trk_w_in [NT][NW];
   logic [NT-1:0]      upd;

   // output register
   pcs_pkg::status_type rsp_status_ff;
   logic [31:0]        rsp_ret_ff, rsp_risk_ff, rsp_shp_ff;
   logic [2:0]         rsp_mask_ff;
   logic [16:0]        rsp_w_ff [NW];

   // units
   logic               mem_we;
   logic [AW-1:0]      mem_raddr;
   logic [31:0]        mem_rdata;
   pcs_pkg::div_req_type div_req;
   pcs_pkg::div_rsp_type div_rsp;
   logic               sqrt_start;
   logic [63:0]        sqrt_x;
   logic               sqrt_done;
   logic [31:0]        sqrt_root;

   pcs_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_we),
      .wr_addr (AW'(idx_ff)),
      .wr_data (value_ff),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   pcs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   pcs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_x),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // asset count clamped to 1..LIM
   always_comb begin
      if (asset_count_ff == 3'd0) begin
         n_eff = IW'(1);
      end else if (32'(asset_count_ff) > LIM) begin
         n_eff = IW'(LIM);
      end else begin
         n_eff = IW'(asset_count_ff);
      end
   end

   always_comb begin
      sum_c = '0;
      for (int k = 0; k < NW; k++) begin
         if (k < 32'(n_ff)) begin
            sum_c = sum_c + 19'(raw_ff[k]);
         end
      end
   end

   always_comb begin
      acc_rnd = acc_ff + 53'sd32768;
      acc_top = acc_rnd[52:16];
      var_rnd = var_acc_ff + 58'sd32768;
      var_top = var_rnd[57:16];
      diff    = {ret_ff[31], ret_ff} - {rate_ff[31], rate_ff};
      mag     = diff[32] ? 33'(-diff) : 33'(diff);
      for (int t = 0; t < NT; t++) begin
         upd[t] = 1'b0;
      end
      upd[0] = !trk_valid_ff[0] || (risk_ff < trk_risk_ff[0]);
      upd[1] = !trk_valid_ff[1] || (ret_ff > trk_ret_ff[1]);
      upd[2] = !trk_valid_ff[2] || (shp_ff > trk_shp_ff[2]);
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      n_in         = n_ff;
      sum_in       = sum_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rowbase_in   = rowbase_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      prod2_in     = prod2_ff;
      var_acc_in   = var_acc_ff;
      neg_in       = neg_ff;
      status_in    = status_ff;
      ret_in       = ret_ff;
      risk_in      = risk_ff;
      shp_in       = shp_ff;
      mask_in      = mask_ff;
      trk_valid_in = trk_valid_ff;
      for (int k = 0; k < NW; k++) begin
         raw_in[k] = raw_ff[k];
         w_in[k]   = w_ff[k];
      end
      for (int t = 0; t < NT; t++) begin
         trk_risk_in[t] = trk_risk_ff[t];
         trk_ret_in[t]  = trk_ret_ff[t];
         trk_shp_in[t]  = trk_shp_ff[t];
         for (int k = 0; k < NW; k++) begin
            trk_w_in[t][k] = trk_w_ff[t][k];
         end
      end
      mem_we     = 1'b0;
      mem_raddr  = '0;
      div_req    = '0;
      sqrt_start = 1'b0;
      sqrt_x     = '0;
      rsp_load   = 1'b0;

      case (state_ff)
         pcs_pkg::S_IDLE: begin
            if (req_valid) begin
               kind_in   = pcs_pkg::kind_type'(req_kind);
               idx_in    = req_entry_index;
               value_in  = req_entry_value;
               raw_in[0] = req_raw_weight_0;
               raw_in[1] = req_raw_weight_1;
               raw_in[2] = req_raw_weight_2;
               raw_in[3] = req_raw_weight_3;
               raw_in[4] = req_raw_weight_4;
               n_in      = n_eff;
               state_in  = pcs_pkg::S_EXEC;
            end
         end
         pcs_pkg::S_EXEC: begin
            status_in  = pcs_pkg::ST_OK;
            ret_in     = '0;
            risk_in    = '0;
            shp_in     = '0;
            mask_in    = '0;
            i_in       = '0;
            j_in       = '0;
            acc_in     = '0;
            var_acc_in = '0;
            rowbase_in = AW'(MAX_ASSETS);
            sum_in     = sum_c;
            for (int k = 0; k < NW; k++) begin
               w_in[k] = '0;
            end
            state_in = pcs_pkg::S_DONE;
            case (kind_ff)
               pcs_pkg::KIND_LOAD: begin
                  if (32'(idx_ff) < DEPTH) begin
                     mem_we = 1'b1;
                  end else begin
                     status_in = pcs_pkg::ST_BAD_INDEX;
                  end
               end
               pcs_pkg::KIND_CLEAR: begin
                  trk_valid_in = '0;
               end
               pcs_pkg::KIND_READ: begin
                  if (32'(idx_ff) < NT) begin
                     if (trk_valid_ff[idx_ff[1:0]]) begin
                        risk_in = trk_risk_ff[idx_ff[1:0]];
                        ret_in  = trk_ret_ff[idx_ff[1:0]];
                        shp_in  = trk_shp_ff[idx_ff[1:0]];
                        for (int k = 0; k < NW; k++) begin
                           w_in[k] = trk_w_ff[idx_ff[1:0]][k];
                        end
                     end else begin
                        risk_in = pcs_pkg::RISK_SENT;
                        ret_in  = pcs_pkg::METRIC_SENT;
                        shp_in  = pcs_pkg::METRIC_SENT;
                     end
                  end else begin
                     status_in = pcs_pkg::ST_BAD_INDEX;
                  end
               end
               pcs_pkg::KIND_EVAL: begin
                  if (sum_c == '0) begin
                     status_in = pcs_pkg::ST_ZERO_SUM;
                  end else begin
                     state_in = pcs_pkg::S_NORM_GO;
                  end
               end
               default: begin
                  status_in = pcs_pkg::ST_OK;
               end
            endcase
         end
         pcs_pkg::S_NORM_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = 50'({raw_ff[i_ff], 16'd0}) + 50'(sum_ff[18:1]);
            div_req.divisor  = 32'(sum_ff);
            state_in         = pcs_pkg::S_NORM_WAIT;
         end
         pcs_pkg::S_NORM_WAIT: begin
            if (div_rsp.done) begin
               w_in[i_ff] = div_rsp.quotient[16:0];
               if (i_ff == n_ff - 1'b1) begin
                  i_in     = '0;
                  state_in = pcs_pkg::S_RET_RD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = pcs_pkg::S_NORM_GO;
               end
            end
         end
         pcs_pkg::S_RET_RD: begin
            mem_raddr = AW'(i_ff);
            state_in  = pcs_pkg::S_RET_MUL;
         end
         pcs_pkg::S_RET_MUL: begin
            prod_in  = $signed({1'b0, w_ff[i_ff]}) * $signed(mem_rdata);
            state_in = pcs_pkg::S_RET_ACC;
         end
         pcs_pkg::S_RET_ACC: begin
            acc_in = acc_ff + 53'(prod_ff);
            if (i_ff == n_ff - 1'b1) begin
               state_in = pcs_pkg::S_RET_FIN;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = pcs_pkg::S_RET_RD;
            end
         end
         pcs_pkg::S_RET_FIN: begin
            if (acc_top[36:31] == 6'b000000 || acc_top[36:31] == 6'b111111) begin
               ret_in = acc_top[31:0];
            end else if (acc_top[36]) begin
               ret_in = pcs_pkg::METRIC_SENT;
            end else begin
               ret_in = 32'h7FFF_FFFF;
            end
            acc_in   = '0;
            i_in     = '0;
            j_in     = '0;
            state_in = pcs_pkg::S_VAR_RD;
         end
         pcs_pkg::S_VAR_RD: begin
            mem_raddr = rowbase_ff + AW'(j_ff);
            state_in  = pcs_pkg::S_VAR_MUL;
         end
         pcs_pkg::S_VAR_MUL: begin
            prod_in  = $signed({1'b0, w_ff[j_ff]}) * $signed(mem_rdata);
            state_in = pcs_pkg::S_VAR_ACC;
         end
         pcs_pkg::S_VAR_ACC: begin
            acc_in = acc_ff + 53'(prod_ff);
            if (j_ff == n_ff - 1'b1) begin
               state_in = pcs_pkg::S_VAR_ROW;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = pcs_pkg::S_VAR_RD;
            end
         end
         pcs_pkg::S_VAR_ROW: begin
            // row term rounded to Q8.24 before the outer weight
            prod2_in = $signed({1'b0, w_ff[i_ff]}) * acc_top;
            state_in = pcs_pkg::S_VAR_ADD;
         end
         pcs_pkg::S_VAR_ADD: begin
            var_acc_in = var_acc_ff + 58'(prod2_ff);
            acc_in     = '0;
            j_in       = '0;
            rowbase_in = rowbase_ff + AW'(MAX_ASSETS);
            if (i_ff == n_ff - 1'b1) begin
               state_in = pcs_pkg::S_VAR_FIN;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = pcs_pkg::S_VAR_RD;
            end
         end
         pcs_pkg::S_VAR_FIN: begin
            sqrt_start = 1'b1;
            sqrt_x     = var_top[41] ? 64'd0 : {var_top[39:0], 24'd0};
            state_in   = pcs_pkg::S_SQRT_WAIT;
         end
         pcs_pkg::S_SQRT_WAIT: begin
            if (sqrt_done) begin
               risk_in  = sqrt_root;
               state_in = pcs_pkg::S_SHP_GO;
            end
         end
         pcs_pkg::S_SHP_GO: begin
            neg_in = diff[32];
            if (risk_ff == '0) begin
               status_in = pcs_pkg::ST_ZERO_RISK;
               if (diff == '0) begin
                  shp_in = '0;
               end else if (diff[32]) begin
                  shp_in = pcs_pkg::METRIC_SENT;
               end else begin
                  shp_in = 32'h7FFF_FFFF;
               end
               state_in = pcs_pkg::S_TRACK;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = 50'({mag, 16'd0}) + 50'(risk_ff[31:1]);
               div_req.divisor  = risk_ff;
               state_in         = pcs_pkg::S_SHP_WAIT;
            end
         end
         pcs_pkg::S_SHP_WAIT: begin
            if (div_rsp.done) begin
               if (neg_ff) begin
                  if (div_rsp.quotient > 50'h0_8000_0000) begin
                     shp_in = pcs_pkg::METRIC_SENT;
                  end else begin
                     shp_in = 32'(-div_rsp.quotient);
                  end
               end else begin
                  if (div_rsp.quotient > 50'h0_7FFF_FFFF) begin
                     shp_in = 32'h7FFF_FFFF;
                  end else begin
                     shp_in = div_rsp.quotient[31:0];
                  end
               end
               state_in = pcs_pkg::S_TRACK;
            end
         end
         pcs_pkg::S_TRACK: begin
            mask_in = upd;
            for (int t = 0; t < NT; t++) begin
               if (upd[t]) begin
                  trk_valid_in[t] = 1'b1;
                  trk_risk_in[t]  = risk_ff;
                  trk_ret_in[t]   = ret_ff;
                  trk_shp_in[t]   = shp_ff;
                  for (int k = 0; k < NW; k++) begin
                     trk_w_in[t][k] = w_ff[k];
                  end
               end
            end
            state_in = pcs_pkg::S_DONE;
         end
         pcs_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = pcs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pcs_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pcs_pkg::S_IDLE;
         rsp_valid_ff   <= 1'b0;
         trk_valid_ff   <= '0;
         asset_count_ff <= pcs_pkg::COUNT_RESET;
         rate_ff        <= pcs_pkg::RATE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         trk_valid_ff <= trk_valid_in;
         if (csr_write && csr_index == pcs_pkg::CSR_ASSET_COUNT) begin
            asset_count_ff <= csr_data[2:0];
         end
         if (csr_write && csr_index == pcs_pkg::CSR_RISK_FREE) begin
            rate_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      idx_ff     <= idx_in;
      value_ff   <= value_in;
      n_ff       <= n_in;
      sum_ff     <= sum_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      rowbase_ff <= rowbase_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      prod2_ff   <= prod2_in;
      var_acc_ff <= var_acc_in;
      neg_ff     <= neg_in;
      status_ff  <= status_in;
      ret_ff     <= ret_in;
      risk_ff    <= risk_in;
      shp_ff     <= shp_in;
      mask_ff    <= mask_in;
      for (int k = 0; k < NW; k++) begin
         raw_ff[k] <= raw_in[k];
         w_ff[k]   <= w_in[k];
      end
      for (int t = 0; t < NT; t++) begin
         trk_risk_ff[t] <= trk_risk_in[t];
         trk_ret_ff[t]  <= trk_ret_in[t];
         trk_shp_ff[t]  <= trk_shp_in[t];
         for (int k = 0; k < NW; k++) begin
            trk_w_ff[t][k] <= trk_w_in[t][k];
         end
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_ret_ff    <= ret_ff;
         rsp_risk_ff   <= risk_ff;
         rsp_shp_ff    <= shp_ff;
         rsp_mask_ff   <= mask_ff;
         for (int k = 0; k < NW; k++) begin
            rsp_w_ff[k] <= w_ff[k];
         end
      end
   end

   assign req_stall         = (state_ff != pcs_pkg::S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_port_return   = rsp_ret_ff;
   assign rsp_port_risk     = rsp_risk_ff;
   assign rsp_sharpe_value  = rsp_shp_ff;
   assign rsp_improved_mask = rsp_mask_ff;
   assign rsp_weight_out_0  = rsp_w_ff[0];
   assign rsp_weight_out_1  = rsp_w_ff[1];
   assign rsp_weight_out_2  = rsp_w_ff[2];
   assign rsp_weight_out_3  = rsp_w_ff[3];
   assign rsp_weight_out_4  = rsp_w_ff[4];

   // a skipped candidate never touches the trackers
   a_zero_sum_no_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == pcs_pkg::ST_ZERO_SUM) |-> (rsp_mask_ff == 3'd0))
      else $error("zero-sum word reports tracker update");

   a_mask_only_eval: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mask_ff != 3'd0) |->
      (rsp_status_ff == pcs_pkg::ST_OK || rsp_status_ff == pcs_pkg::ST_ZERO_RISK))
      else $error("tracker update on a non-evaluate word");

   a_weight_le_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcs_pkg::S_NORM_WAIT && div_rsp.done) |->
      (div_rsp.quotient <= 50'd65536))
      else $error("normalized weight above one");

   a_sqrt_when_waiting: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == pcs_pkg::S_SQRT_WAIT))
      else $error("square root finished outside its wait state");

endmodule
